// ===== sv/tsp_pkg.sv =====
// Shared types, constants and coefficient table of the Taylor sample predictor.
`default_nettype none

package tsp_pkg;

    // Field widths
    localparam int SAMPLE_W   = 16;
    localparam int CHAN_W     = 3;
    localparam int DEG_W      = 3;
    localparam int CCNT_W     = 4;
    localparam int USED_W     = CCNT_W + 1;

    // Configuration port
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 4;
    localparam logic [CFG_ADDR_W-1:0] CFG_DEGREE        = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_CHANNEL_COUNT = 1'b1;

    // Arithmetic widths: Q16 tap weights, products and the accumulated sum
    localparam int TABLE_TAPS = 8;
    localparam int COEF_W     = 19;
    localparam int PROD_W     = SAMPLE_W + COEF_W;
    localparam int ACC_W      = PROD_W + 3;
    localparam int FRAC_W     = 16;
    localparam int RND_W      = ACC_W - FRAC_W;

    // Rounding offset and clamp limits
    localparam logic [ACC_W-1:0] HALF_LSB  = ACC_W'(1 << (FRAC_W - 1));
    localparam logic [RND_W-1:0] NEG_LIMIT = RND_W'(1 << 15);
    localparam logic [RND_W-1:0] POS_LIMIT = RND_W'((1 << 15) - 1);

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic [CHAN_W-1:0]          t_chan;
    typedef logic [DEG_W-1:0]           t_deg;

    // Combined weight of tap i for prediction order d: the sum over orders
    // 1..d of (-1)^i / (i! (n-i)!) in Q16, plus one on the newest tap.
    localparam logic signed [COEF_W-1:0] COEF_TABLE [TABLE_TAPS][TABLE_TAPS] = '{
        '{ 19'sd65536,       19'sd0,      19'sd0,      19'sd0,
           19'sd0,           19'sd0,      19'sd0,      19'sd0 },
        '{ 19'sd131072,     -19'sd65536,  19'sd0,      19'sd0,
           19'sd0,           19'sd0,      19'sd0,      19'sd0 },
        '{ 19'sd163840,     -19'sd131072, 19'sd32768,  19'sd0,
           19'sd0,           19'sd0,      19'sd0,      19'sd0 },
        '{ 19'sd174763,     -19'sd163840, 19'sd65536, -19'sd10923,
           19'sd0,           19'sd0,      19'sd0,      19'sd0 },
        '{ 19'sd177494,     -19'sd174763, 19'sd81920, -19'sd21846,
           19'sd2731,        19'sd0,      19'sd0,      19'sd0 },
        '{ 19'sd178040,     -19'sd177494, 19'sd87381, -19'sd27307,
           19'sd5462,       -19'sd546,    19'sd0,      19'sd0 },
        '{ 19'sd178131,     -19'sd178040, 19'sd88746, -19'sd29127,
           19'sd6827,       -19'sd1092,   19'sd91,     19'sd0 },
        '{ 19'sd178144,     -19'sd178131, 19'sd89019, -19'sd29582,
           19'sd7282,       -19'sd1365,   19'sd182,   -19'sd13 }
    };

    // Tap word handed from the history store to the multiply-accumulate
    typedef struct packed {
        logic [TABLE_TAPS-1:0][SAMPLE_W-1:0] tap;  // newest first, unused taps zero
        t_chan                               chan;
        t_deg                                deg;
        logic                                pass; // forward tap 0 unchanged
    } t_tap_word;

endpackage

`default_nettype wire

// ===== sv/tsp_in_if.sv =====
// Input channel: one sample word with its channel tag.
`default_nettype none

interface tsp_in_if
    import tsp_pkg::*;
();
    logic    valid;
    logic    ready;
    t_sample sample;
    t_chan   channel;

    modport source (output valid, output sample, output channel, input ready);
    modport sink   (input valid, input sample, input channel, output ready);
endinterface

`default_nettype wire

// ===== sv/tsp_out_if.sv =====
// Output channel: one prediction word with its channel tag.
`default_nettype none

interface tsp_out_if
    import tsp_pkg::*;
();
    logic    valid;
    logic    ready;
    t_sample prediction;
    t_chan   out_channel;

    modport source (output valid, output prediction, output out_channel, input ready);
    modport sink   (input valid, input prediction, input out_channel, output ready);
endinterface

`default_nettype wire

// ===== sv/tsp_history.sv =====
// Per-channel sample history and sample count, with tap word formation.
`default_nettype none

module tsp_history
    import tsp_pkg::*;
#(
    parameter int MAX_DEGREE = 7,
    parameter int CHANNELS   = 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_we,
    input  wire t_sample           i_sample,
    input  wire t_chan             i_chan,
    input  wire logic [USED_W-1:0] i_used,
    input  wire t_deg              i_deg,
    output t_tap_word              o_word
);

    localparam int TAPS  = MAX_DEGREE + 1;
    localparam int CNT_W = $clog2(TAPS + 1);
    localparam int ROWS  = (CHANNELS < (1 << CHAN_W)) ? CHANNELS : (1 << CHAN_W);
    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

    logic [TAPS-1:0][SAMPLE_W-1:0] r_hist [ROWS];
    logic [CNT_W-1:0]              r_cnt  [ROWS];

    logic [TAPS-1:0][SAMPLE_W-1:0] cur_row;
    logic [TAPS-1:0][SAMPLE_W-1:0] n_row;
    logic [CNT_W-1:0]              cur_cnt;
    logic [CNT_W-1:0]              n_cnt;
    logic [ROW_W-1:0]              idx;
    logic                          in_use;
    logic                          wr;

    assign idx     = i_chan[ROW_W-1:0];
    assign in_use  = {{(USED_W - CHAN_W){1'b0}}, i_chan} < i_used;
    assign wr      = i_we && in_use;
    assign cur_row = r_hist[idx];
    assign cur_cnt = r_cnt[idx];

    // Shift the new sample in and advance the saturating count
    assign n_row = {cur_row[TAPS-2:0], i_sample};
    assign n_cnt = (cur_cnt == CNT_W'(TAPS)) ? cur_cnt : cur_cnt + 1'b1;

    for (genvar g = 0; g < ROWS; g++) begin : g_row
        // Hold history rows; no reset, only written entries are read
        always_ff @(posedge i_clk) begin
            if (wr && idx == ROW_W'(g)) begin
                r_hist[g] <= n_row;
            end
        end

        // Clear counts at reset
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_cnt[g] <= '0;
            end else if (wr && idx == ROW_W'(g)) begin
                r_cnt[g] <= n_cnt;
            end
        end
    end

    // Build the tap word: drop taps past the stored count, zero idle channels
    always_comb begin
        o_word      = '0;
        o_word.chan = i_chan;
        o_word.deg  = i_deg;
        o_word.pass = !in_use || ({1'b0, i_deg} >= 4'(n_cnt));
        for (int i = 0; i < TABLE_TAPS; i++) begin
            if (i < TAPS && in_use && i < int'(n_cnt)) begin
                o_word.tap[i] = n_row[i];
            end
        end
    end

endmodule

`default_nettype wire

// ===== sv/tsp_mac.sv =====
// Weighted sum of the history taps with the Q16 Taylor weights.
`default_nettype none

module tsp_mac
    import tsp_pkg::*;
(
    input  wire t_tap_word          i_word,
    output logic signed [ACC_W-1:0] o_acc
);

    logic signed [PROD_W-1:0] prod;

    // Multiply each tap by its weight and sum
    always_comb begin
        o_acc = '0;
        prod  = '0;
        for (int i = 0; i < TABLE_TAPS; i++) begin
            prod  = $signed(i_word.tap[i]) * COEF_TABLE[i_word.deg][i];
            o_acc = o_acc + ACC_W'(prod);
        end
    end

endmodule

`default_nettype wire

// ===== sv/taylor_difference_sample_predictor.sv =====
// Top level of the Taylor finite-difference sample predictor.
//
// Usage: samples arrive on i_in (valid/ready, sample plus channel tag) and
// one prediction word per sample leaves on o_out with the same channel tag.
// Configuration is written through i_cfg_we / i_cfg_addr / i_cfg_wdata while
// the block is idle: index CFG_DEGREE sets the prediction order, index
// CFG_CHANNEL_COUNT the number of interleaved channels in use.
// Pipeline: input register, history update, multiply-accumulate register,
// round/clamp output register. One word is taken every cycle while the
// receiver does not stall; the path through the history row read, shift
// and write-back is what lets a channel repeat back to back. Reset clears
// all sample counts, the pipeline and the configuration (order 0, one
// channel). When the receiver stalls, words stay in the pipeline registers
// and the input keeps accepting until all four hold a word; a word for a
// channel not in use leaves with a prediction of 0.
`default_nettype none

module taylor_difference_sample_predictor
    import tsp_pkg::*;
#(
    parameter int MAX_DEGREE = 7,
    parameter int CHANNELS   = 8
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata,
    tsp_in_if.sink                     i_in,
    tsp_out_if.source                  o_out
);

    // Configuration registers
    t_deg              r_degree;
    logic [CCNT_W-1:0] r_chan_count;
    t_deg              deg_eff;
    logic [USED_W-1:0] used_eff;

    // Pipeline registers
    logic                     r_s1_v;
    t_sample                  r_s1_sample;
    t_chan                    r_s1_chan;
    logic                     r_s2_v;
    t_tap_word                r_s2;
    logic                     r_s3_v;
    logic signed [ACC_W-1:0]  r_s3_acc;
    logic                     r_s3_pass;
    t_sample                  r_s3_tap0;
    t_chan                    r_s3_chan;
    logic                     r_out_v;
    t_sample                  r_out_pred;
    t_chan                    r_out_chan;

    logic                     s1_ready;
    logic                     s2_ready;
    logic                     s3_ready;
    logic                     s4_ready;
    t_tap_word                hist_word;
    logic signed [ACC_W-1:0]  acc;

    // Rounding signals
    logic                     neg;
    logic [ACC_W-1:0]         mag;
    logic [ACC_W-1:0]         mag_half;
    logic [RND_W-1:0]         rnd;
    logic [RND_W-1:0]         rnd_clamp;
    logic [RND_W-1:0]         rnd_neg;
    t_sample                  n_out_pred;

    // Decode configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_degree     <= '0;
            r_chan_count <= CCNT_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_DEGREE:        r_degree     <= i_cfg_wdata[DEG_W-1:0];
                CFG_CHANNEL_COUNT: r_chan_count <= i_cfg_wdata[CCNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamp the order and the channel count to the built sizes; a count of zero means one channel
    assign deg_eff = (r_degree > DEG_W'(MAX_DEGREE)) ? DEG_W'(MAX_DEGREE) : r_degree;

    always_comb begin
        used_eff = {1'b0, r_chan_count};
        if (r_chan_count == '0) begin
            used_eff = USED_W'(1);
        end else if (used_eff > USED_W'(CHANNELS)) begin
            used_eff = USED_W'(CHANNELS);
        end
    end

    // Stage readiness: a stage advances when empty or when the next one moves
    assign s4_ready   = !r_out_v || o_out.ready;
    assign s3_ready   = !r_s3_v || s4_ready;
    assign s2_ready   = !r_s2_v || s3_ready;
    assign s1_ready   = !r_s1_v || s2_ready;
    assign i_in.ready = s1_ready;

    // Capture the input word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (s1_ready) begin
            r_s1_v <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_ready && i_in.valid) begin
            r_s1_sample <= i_in.sample;
            r_s1_chan   <= i_in.channel;
        end
    end

    // Update history and form the tap word
    tsp_history #(
        .MAX_DEGREE (MAX_DEGREE),
        .CHANNELS   (CHANNELS)
    ) u_history (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_we     (r_s1_v && s2_ready),
        .i_sample (r_s1_sample),
        .i_chan   (r_s1_chan),
        .i_used   (used_eff),
        .i_deg    (deg_eff),
        .o_word   (hist_word)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else if (s2_ready) begin
            r_s2_v <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_ready && r_s1_v) begin
            r_s2 <= hist_word;
        end
    end

    // Accumulate weighted taps
    tsp_mac u_mac (
        .i_word (r_s2),
        .o_acc  (acc)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_v <= 1'b0;
        end else if (s3_ready) begin
            r_s3_v <= r_s2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s3_ready && r_s2_v) begin
            r_s3_acc  <= acc;
            r_s3_pass <= r_s2.pass;
            r_s3_tap0 <= $signed(r_s2.tap[0]);
            r_s3_chan <= r_s2.chan;
        end
    end

    // Round half away from zero, then clamp to the sample range; pass words forward tap 0
    always_comb begin
        neg       = r_s3_acc[ACC_W-1];
        mag       = neg ? ACC_W'(0) - r_s3_acc : r_s3_acc;
        mag_half  = mag + HALF_LSB;
        rnd       = mag_half[ACC_W-1:FRAC_W];
        rnd_clamp = rnd;
        if (neg && rnd > NEG_LIMIT) begin
            rnd_clamp = NEG_LIMIT;
        end else if (!neg && rnd > POS_LIMIT) begin
            rnd_clamp = POS_LIMIT;
        end
        rnd_neg = RND_W'(0) - rnd_clamp;
        if (r_s3_pass) begin
            n_out_pred = r_s3_tap0;
        end else if (neg) begin
            n_out_pred = $signed(rnd_neg[SAMPLE_W-1:0]);
        end else begin
            n_out_pred = $signed(rnd_clamp[SAMPLE_W-1:0]);
        end
    end

    // Hold the result word until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (s4_ready) begin
            r_out_v <= r_s3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s4_ready && r_s3_v) begin
            r_out_pred <= n_out_pred;
            r_out_chan <= r_s3_chan;
        end
    end

    assign o_out.valid       = r_out_v;
    assign o_out.prediction  = r_out_pred;
    assign o_out.out_channel = r_out_chan;

endmodule

`default_nettype wire
